// File: design/vec3a_pkg.sv
`default_nettype none

package vec3a_pkg;

    // Operation codes
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_NEG   = 4'd1,
        OP_SUB   = 4'd2,
        OP_DOT   = 4'd3,
        OP_CROSS = 4'd4,
        OP_SCALE = 4'd5,
        OP_DIV   = 4'd6,
        OP_LEN   = 4'd7,
        OP_NORM  = 4'd8
    } t_op;

    // Iterations of the root and quotient pipelines
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    // Clamped value with its saturation flag
    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } t_sat;

    // Request fields carried alongside the arithmetic
    typedef struct packed {
        logic               valid;
        logic [3:0]         op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] k;
    } t_side0;

    typedef struct packed {
        logic               valid;
        logic [3:0]         op;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] k;
        t_sat               res_x;
        t_sat               res_y;
        t_sat               res_z;
        t_sat               dot;
    } t_side1;

    typedef struct packed {
        logic       valid;
        logic [3:0] op;
        logic       k_zero;
        logic       len_zero;
        t_sat       len_q;
        t_sat       res_x;
        t_sat       res_y;
        t_sat       res_z;
        t_sat       dot;
    } t_side2;

    // Result fields
    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] scalar_result;
        logic               saturated;
        logic               divide_by_zero;
    } t_rsp;

    // Round to nearest, ties up, dropping f fraction bits
    function automatic logic signed [65:0] round_q(input logic signed [65:0] v,
                                                   input int unsigned f);
        logic signed [65:0] bias;
        bias = 66'sd1 <<< (f - 1);
        return (v + bias) >>> f;
    endfunction

    // Clamp to the signed 32-bit range
    function automatic t_sat clamp_q(input logic signed [65:0] v);
        t_sat res;
        if (v > 66'sd2147483647) begin
            res.val = 32'sh7FFFFFFF;
            res.sat = 1'b1;
        end else if (v < -66'sd2147483648) begin
            res.val = 32'sh80000000;
            res.sat = 1'b1;
        end else begin
            res.val = v[31:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/vec3a_if.sv
`default_nettype none

interface vec3a_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] scale_factor;

    modport source (output valid, opcode, ax, ay, az, bx, by, bz, scale_factor,
                    input ready);
    modport sink (input valid, opcode, ax, ay, az, bx, by, bz, scale_factor,
                  output ready);
endinterface

interface vec3a_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] scalar_result;
    logic               saturated;
    logic               divide_by_zero;

    modport source (output valid, rx, ry, rz, scalar_result, saturated, divide_by_zero,
                    input ready);
    modport sink (input valid, rx, ry, rz, scalar_result, saturated, divide_by_zero,
                  output ready);
endinterface

`default_nettype wire

// File: design/vec3a_dly.sv
`default_nettype none

module vec3a_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_q [DEPTH];

    // Advance the line on each enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_q[i] <= '0;
            end
        end else if (i_en) begin
            r_q[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_q[i] <= r_q[i-1];
            end
        end
    end

    assign o_q = r_q[DEPTH-1];

endmodule

`default_nettype wire

// File: design/vec3a_lane.sv
`default_nettype none

module vec3a_lane #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [3:0]         i_op,
    input  logic signed [31:0] i_a_own,
    input  logic signed [31:0] i_a_next,
    input  logic signed [31:0] i_a_prev,
    input  logic signed [31:0] i_b_own,
    input  logic signed [31:0] i_b_next,
    input  logic signed [31:0] i_b_prev,
    input  logic signed [31:0] i_k,
    output logic signed [63:0] o_p_dot,
    output logic signed [63:0] o_p_sq,
    output vec3a_pkg::t_sat    o_res
);
    import vec3a_pkg::*;

    logic [3:0]         r_op;
    logic signed [31:0] r_a;
    logic signed [31:0] r_b;
    logic signed [63:0] r_p_dot;
    logic signed [63:0] r_p_sq;
    logic signed [63:0] r_p_c0;
    logic signed [63:0] r_p_c1;
    logic signed [63:0] r_p_sc;
    t_sat               n_res;
    t_sat               r_res;

    // Form the products of this component
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op    <= i_op;
            r_a     <= i_a_own;
            r_b     <= i_b_own;
            r_p_dot <= i_a_own * i_b_own;
            r_p_sq  <= i_a_own * i_a_own;
            r_p_c0  <= i_a_next * i_b_prev;
            r_p_c1  <= i_a_prev * i_b_next;
            r_p_sc  <= i_a_own * i_k;
        end
    end

    // Select, round and clamp the element-wise result
    always_comb begin
        case (r_op)
            OP_ADD:   n_res = clamp_q(66'(r_a) + 66'(r_b));
            OP_NEG:   n_res = clamp_q(-66'(r_a));
            OP_SUB:   n_res = clamp_q(66'(r_a) - 66'(r_b));
            OP_CROSS: n_res = clamp_q(round_q(66'(r_p_c0) - 66'(r_p_c1), FRACTION_BITS));
            OP_SCALE: n_res = clamp_q(round_q(66'(r_p_sc), FRACTION_BITS));
            default:  n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_p_dot = r_p_dot;
    assign o_p_sq  = r_p_sq;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// File: design/vec3a_sqrt.sv
`default_nettype none

module vec3a_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_x,
    output logic [32:0] o_len
);
    import vec3a_pkg::*;

    logic [33:0] r_rem  [SQRT_STEPS];
    logic [31:0] r_root [SQRT_STEPS];
    logic [63:0] r_x    [SQRT_STEPS];
    logic [32:0] r_len;

    // One root bit per stage
    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        logic [33:0] p_rem;
        logic [31:0] p_root;
        logic [63:0] p_x;
        logic [35:0] sh;
        logic [35:0] trial;
        logic        ge;

        if (s == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_x    = i_x;
        end else begin : g_rest
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign p_x    = r_x[s-1];
        end

        assign sh    = {p_rem, p_x[63:62]};
        assign trial = {2'b00, p_root, 2'b01};
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? 34'(sh - trial) : sh[33:0];
                r_root[s] <= {p_root[30:0], ge};
                r_x[s]    <= {p_x[61:0], 2'b00};
            end
        end
    end

    // Round to nearest using the final remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (34'(r_rem[SQRT_STEPS-1]) > 34'(r_root[SQRT_STEPS-1])) begin
                r_len <= 33'(r_root[SQRT_STEPS-1]) + 33'd1;
            end else begin
                r_len <= 33'(r_root[SQRT_STEPS-1]);
            end
        end
    end

    assign o_len = r_len;

endmodule

`default_nettype wire

// File: design/vec3a_div.sv
`default_nettype none

module vec3a_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [33:0] i_d,
    output vec3a_pkg::t_sat    o_res
);
    import vec3a_pkg::*;

    logic signed [65:0] n_num;
    logic signed [65:0] n_x;
    logic signed [33:0] n_dd;
    logic [34:0]        n_y;
    logic               n_neg;
    logic [62:0]        n_ax;
    logic               n_ovf;

    logic [62:0] r_ax;
    logic [34:0] r_y;
    logic        r_neg;
    logic        r_ovf;

    logic [34:0] r_rem  [DIV_STEPS];
    logic [31:0] r_lo   [DIV_STEPS];
    logic [31:0] r_q    [DIV_STEPS];
    logic [34:0] r_ys   [DIV_STEPS];
    logic        r_negs [DIV_STEPS];
    logic        r_ovfs [DIV_STEPS];

    logic [32:0]        n_mag;
    logic signed [65:0] n_val;
    t_sat               n_res;
    t_sat               r_res;

    // Fold signs: quotient is floor((2n + d) / 2d) with d positive
    always_comb begin
        n_num = 66'(i_a) <<< FRACTION_BITS;
        n_dd  = i_d;
        if (i_d < 0) begin
            n_num = -n_num;
            n_dd  = -i_d;
        end
        n_x   = (n_num <<< 1) + 66'(n_dd);
        n_y   = {n_dd, 1'b0};
        n_neg = n_x[65];
        n_ax  = n_neg ? 63'(-n_x) : 63'(n_x);
        n_ovf = (35'(n_ax[62:32]) >= n_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax  <= n_ax;
            r_y   <= n_y;
            r_neg <= n_neg;
            r_ovf <= n_ovf;
        end
    end

    // One quotient bit per stage
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
        logic [34:0] p_rem;
        logic [31:0] p_lo;
        logic [31:0] p_q;
        logic [34:0] p_y;
        logic        p_neg;
        logic        p_ovf;
        logic [35:0] sh;
        logic        ge;

        if (s == 0) begin : g_first
            assign p_rem = 35'(r_ax[62:32]);
            assign p_lo  = r_ax[31:0];
            assign p_q   = '0;
            assign p_y   = r_y;
            assign p_neg = r_neg;
            assign p_ovf = r_ovf;
        end else begin : g_rest
            assign p_rem = r_rem[s-1];
            assign p_lo  = r_lo[s-1];
            assign p_q   = r_q[s-1];
            assign p_y   = r_ys[s-1];
            assign p_neg = r_negs[s-1];
            assign p_ovf = r_ovfs[s-1];
        end

        assign sh = {p_rem, p_lo[31]};
        assign ge = (sh >= {1'b0, p_y});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= ge ? 35'(sh - {1'b0, p_y}) : sh[34:0];
                r_lo[s]   <= {p_lo[30:0], 1'b0};
                r_q[s]    <= {p_q[30:0], ge};
                r_ys[s]   <= p_y;
                r_negs[s] <= p_neg;
                r_ovfs[s] <= p_ovf;
            end
        end
    end

    // Apply sign, round toward minus infinity for negatives, clamp
    always_comb begin
        n_mag = 33'(r_q[DIV_STEPS-1]) + 33'(r_rem[DIV_STEPS-1] != '0);
        if (r_negs[DIV_STEPS-1]) begin
            n_val = -66'(n_mag);
        end else begin
            n_val = 66'(r_q[DIV_STEPS-1]);
        end
        n_res = clamp_q(n_val);
        if (r_ovfs[DIV_STEPS-1]) begin
            n_res.val = r_negs[DIV_STEPS-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
            n_res.sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// File: design/vector3_alu_top.sv
// Throughput: one request per cycle while the skid entry is free; the three
// component lanes, the 32-stage root pipeline and the three 32-stage quotient
// pipelines all advance together.
// A full output register plus one skid entry pause the pipeline on back-pressure.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
`default_nettype none

module vector3_alu_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vec3a_req_if.sink   i_req,
    vec3a_rsp_if.source o_rsp
);
    import vec3a_pkg::*;

    localparam int LEN_LAT = SQRT_STEPS + 1;
    localparam int DIV_LAT = DIV_STEPS + 2;

    logic en;

    t_side0             r_s0;
    logic signed [31:0] r_bx;
    logic signed [31:0] r_by;
    logic signed [31:0] r_bz;

    logic signed [63:0] p_dot [3];
    logic signed [63:0] p_sq  [3];
    t_sat               lane_res [3];

    t_sat        n_dot;
    t_sat        r_dot;
    logic [63:0] n_sq;
    logic [63:0] r_sq;

    logic [$bits(t_side0)-1:0] w_s0d;
    t_side0                    s0d;
    t_side1                    n_s1;
    logic [$bits(t_side1)-1:0] w_s1d;
    t_side1                    s1d;
    t_side2                    n_s2;
    logic [$bits(t_side2)-1:0] w_s2d;
    t_side2                    s2d;

    logic [32:0]        len;
    logic signed [33:0] n_div_d;
    t_sat               div_res [3];

    t_rsp n_rsp;
    t_rsp r_out;
    logic r_out_valid;
    t_rsp r_skid;
    logic r_skid_valid;

    // Pipeline advances while the skid entry is free
    assign en          = !r_skid_valid;
    assign i_req.ready = en;

    // Register the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (en) begin
            r_s0.valid <= i_req.valid;
            r_s0.op    <= i_req.opcode;
            r_s0.ax    <= i_req.ax;
            r_s0.ay    <= i_req.ay;
            r_s0.az    <= i_req.az;
            r_s0.k     <= i_req.scale_factor;
            r_bx       <= i_req.bx;
            r_by       <= i_req.by;
            r_bz       <= i_req.bz;
        end
    end

    // Component lanes
    vec3a_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_op(r_s0.op),
        .i_a_own(r_s0.ax), .i_a_next(r_s0.ay), .i_a_prev(r_s0.az),
        .i_b_own(r_bx), .i_b_next(r_by), .i_b_prev(r_bz), .i_k(r_s0.k),
        .o_p_dot(p_dot[0]), .o_p_sq(p_sq[0]), .o_res(lane_res[0])
    );

    vec3a_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_op(r_s0.op),
        .i_a_own(r_s0.ay), .i_a_next(r_s0.az), .i_a_prev(r_s0.ax),
        .i_b_own(r_by), .i_b_next(r_bz), .i_b_prev(r_bx), .i_k(r_s0.k),
        .o_p_dot(p_dot[1]), .o_p_sq(p_sq[1]), .o_res(lane_res[1])
    );

    vec3a_lane #(.FRACTION_BITS(FRACTION_BITS)) u_lane_z (
        .i_clk(i_clk), .i_en(en), .i_op(r_s0.op),
        .i_a_own(r_s0.az), .i_a_next(r_s0.ax), .i_a_prev(r_s0.ay),
        .i_b_own(r_bz), .i_b_next(r_bx), .i_b_prev(r_by), .i_k(r_s0.k),
        .o_p_dot(p_dot[2]), .o_p_sq(p_sq[2]), .o_res(lane_res[2])
    );

    // Merge lane products: dot product and sum of squares
    always_comb begin
        n_dot = clamp_q(round_q(66'(p_dot[0]) + 66'(p_dot[1]) + 66'(p_dot[2]),
                                FRACTION_BITS));
        n_sq  = $unsigned(p_sq[0]) + $unsigned(p_sq[1]) + $unsigned(p_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dot <= n_dot;
            r_sq  <= n_sq;
        end
    end

    // Carry request fields past the lanes
    vec3a_dly #(.WIDTH($bits(t_side0)), .DEPTH(2)) u_dly0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(r_s0), .o_q(w_s0d)
    );
    assign s0d = t_side0'(w_s0d);

    always_comb begin
        n_s1.valid = s0d.valid;
        n_s1.op    = s0d.op;
        n_s1.ax    = s0d.ax;
        n_s1.ay    = s0d.ay;
        n_s1.az    = s0d.az;
        n_s1.k     = s0d.k;
        n_s1.res_x = lane_res[0];
        n_s1.res_y = lane_res[1];
        n_s1.res_z = lane_res[2];
        n_s1.dot   = r_dot;
    end

    // Length
    vec3a_sqrt u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_x(r_sq), .o_len(len)
    );

    vec3a_dly #(.WIDTH($bits(t_side1)), .DEPTH(LEN_LAT)) u_dly1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(n_s1), .o_q(w_s1d)
    );
    assign s1d = t_side1'(w_s1d);

    // Divisor is the scalar or the length
    always_comb begin
        if (s1d.op == OP_DIV) begin
            n_div_d = 34'(s1d.k);
        end else begin
            n_div_d = $signed(34'(len));
        end
    end

    vec3a_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_x (
        .i_clk(i_clk), .i_en(en), .i_a(s1d.ax), .i_d(n_div_d), .o_res(div_res[0])
    );

    vec3a_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_y (
        .i_clk(i_clk), .i_en(en), .i_a(s1d.ay), .i_d(n_div_d), .o_res(div_res[1])
    );

    vec3a_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_z (
        .i_clk(i_clk), .i_en(en), .i_a(s1d.az), .i_d(n_div_d), .o_res(div_res[2])
    );

    always_comb begin
        n_s2.valid    = s1d.valid;
        n_s2.op       = s1d.op;
        n_s2.k_zero   = (s1d.k == '0);
        n_s2.len_zero = (len == '0);
        n_s2.len_q    = clamp_q(66'(len));
        n_s2.res_x    = s1d.res_x;
        n_s2.res_y    = s1d.res_y;
        n_s2.res_z    = s1d.res_z;
        n_s2.dot      = s1d.dot;
    end

    vec3a_dly #(.WIDTH($bits(t_side2)), .DEPTH(DIV_LAT)) u_dly2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_d(n_s2), .o_q(w_s2d)
    );
    assign s2d = t_side2'(w_s2d);

    // Select the result by operation
    always_comb begin
        n_rsp = '0;
        case (s2d.op)
            OP_ADD, OP_NEG, OP_SUB, OP_CROSS, OP_SCALE: begin
                n_rsp.rx        = s2d.res_x.val;
                n_rsp.ry        = s2d.res_y.val;
                n_rsp.rz        = s2d.res_z.val;
                n_rsp.saturated = s2d.res_x.sat | s2d.res_y.sat | s2d.res_z.sat;
            end
            OP_DOT: begin
                n_rsp.scalar_result = s2d.dot.val;
                n_rsp.saturated     = s2d.dot.sat;
            end
            OP_DIV: begin
                if (s2d.k_zero) begin
                    n_rsp.divide_by_zero = 1'b1;
                end else begin
                    n_rsp.rx        = div_res[0].val;
                    n_rsp.ry        = div_res[1].val;
                    n_rsp.rz        = div_res[2].val;
                    n_rsp.saturated = div_res[0].sat | div_res[1].sat | div_res[2].sat;
                end
            end
            OP_LEN: begin
                n_rsp.scalar_result = s2d.len_q.val;
                n_rsp.saturated     = s2d.len_q.sat;
            end
            OP_NORM: begin
                if (!s2d.len_zero) begin
                    n_rsp.rx        = div_res[0].val;
                    n_rsp.ry        = div_res[1].val;
                    n_rsp.rz        = div_res[2].val;
                    n_rsp.saturated = div_res[0].sat | div_res[1].sat | div_res[2].sat;
                end
            end
            default: n_rsp = '0;
        endcase
    end

    // Output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_rsp.ready) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (s2d.valid) begin
            if (!r_out_valid || o_rsp.ready) begin
                r_out       <= n_rsp;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= n_rsp;
                r_skid_valid <= 1'b1;
            end
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.rx             = r_out.rx;
    assign o_rsp.ry             = r_out.ry;
    assign o_rsp.rz             = r_out.rz;
    assign o_rsp.scalar_result  = r_out.scalar_result;
    assign o_rsp.saturated      = r_out.saturated;
    assign o_rsp.divide_by_zero = r_out.divide_by_zero;

`ifndef NO_ASSERTIONS
    // Skid entry only ever backs a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a request while the output is empty");

    // Skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !o_rsp.ready))
        else $error("skid entry filled without back-pressure");

    // Division by zero gives the zero vector and no saturation
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.divide_by_zero) |->
            (!o_rsp.saturated && o_rsp.rx == '0 && o_rsp.ry == '0 && o_rsp.rz == '0))
        else $error("divide by zero result is not clean");
`endif

endmodule

`default_nettype wire
